// ===== src/kac_pkg.sv =====
// ----------------------------------------------------------------------------
// kac_pkg: shared types and constants of the keyed access controller
// command characters, field widths, reset values and stream payloads
// ----------------------------------------------------------------------------
`default_nettype none

package kac_pkg;

  // field widths
  localparam int unsigned LETTER_W = 4;   // code letter as its low ascii nibble
  localparam int unsigned HOLD_W   = 14;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned DEC_W    = 2;
  localparam int unsigned BLINK_W  = 2;

  // operation codes
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // entry decision codes
  localparam logic [DEC_W-1:0] DEC_NONE  = 2'd0;
  localparam logic [DEC_W-1:0] DEC_GRANT = 2'd1;
  localparam logic [DEC_W-1:0] DEC_DENY  = 2'd2;

  // blink requests
  localparam logic [BLINK_W-1:0] BLINK_NONE   = 2'd0;
  localparam logic [BLINK_W-1:0] BLINK_SINGLE = 2'd1;
  localparam logic [BLINK_W-1:0] BLINK_TEST   = 2'd3;

  // command characters
  localparam logic [7:0] CH_DIGIT_LO = "0";
  localparam logic [7:0] CH_DIGIT_HI = "9";
  localparam logic [7:0] CH_ENTER    = "1";
  localparam logic [7:0] CH_ENABLES  = "2";
  localparam logic [7:0] CH_HOURS    = "3";
  localparam logic [7:0] CH_MINUTES  = "4";
  localparam logic [7:0] CH_DELAY    = "5";
  localparam logic [7:0] CH_CHECK    = "6";
  localparam logic [7:0] CH_CHANGE   = "7";
  localparam logic [7:0] CH_FORMER   = "8";
  localparam logic [7:0] CH_IDLE     = "~";
  localparam logic [7:0] CH_UP_A     = "A";
  localparam logic [7:0] CH_UP_D     = "D";
  localparam logic [7:0] CH_UP_J     = "J";
  localparam logic [7:0] CH_UP_K     = "K";
  localparam logic [7:0] CH_UP_M     = "M";
  localparam logic [7:0] CH_UP_X     = "X";
  localparam logic [7:0] CH_LO_A     = "a";
  localparam logic [7:0] CH_LO_J     = "j";
  localparam logic [7:0] CH_LO_M     = "m";
  localparam logic [7:0] CH_LO_X     = "x";
  localparam logic [7:0] CH_LO_Z     = "z";
  localparam logic [7:0] CH_BAR      = "|";

  // clock limits and reset values
  localparam logic [MIN_W-1:0]  MINUTE_WRAP    = 6'd60;
  localparam logic [HOUR_W-1:0] HOUR_LAST      = 5'd23;
  localparam logic [HOUR_W-1:0] WORK_HOURS_RST = 5'd8;
  localparam logic [HOLD_W-1:0] HOLD_RST       = 14'd5000;
  localparam logic [HOLD_W-1:0] HOLD_STEP      = 14'd1000;
  localparam int unsigned       RESET_CODE_LEN = 4;   // "ABCD"

  typedef struct packed {
    logic       operation;
    logic       has_byte;
    logic [7:0] rx_byte;
    logic       sensor_level;
  } kac_in_t;

  typedef struct packed {
    logic [DEC_W-1:0]   entry_decision;
    logic [HOLD_W-1:0]  hold_ms;
    logic [BLINK_W-1:0] green_blinks;
    logic [BLINK_W-1:0] red_blinks;
    logic               relay_on;
    logic               green_on;
    logic               red_on;
  } kac_out_t;

endpackage

`default_nettype wire

// ===== src/kac_stream_if.sv =====
// ----------------------------------------------------------------------------
// kac_stream_if: valid/ready item channel
// carries one payload item per handshake, source drives valid and payload
// ----------------------------------------------------------------------------
`default_nettype none

interface kac_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/kac_code_eq.sv =====
// ----------------------------------------------------------------------------
// kac_code_eq: code comparator
// two codes match when lengths agree and every letter below the length agrees
// ----------------------------------------------------------------------------
`default_nettype none

module kac_code_eq #(
  parameter int unsigned CODE_LEN = 8
) (
  input  logic [kac_pkg::LETTER_W-1:0]   a_code_i [CODE_LEN],
  input  logic [$clog2(CODE_LEN+1)-1:0] a_len_i,
  input  logic [kac_pkg::LETTER_W-1:0]   b_code_i [CODE_LEN],
  input  logic [$clog2(CODE_LEN+1)-1:0] b_len_i,
  output logic                          equal_o
);

  localparam int unsigned LEN_W = $clog2(CODE_LEN + 1);

  logic [CODE_LEN-1:0] mismatch;

  always_comb begin
    for (int i = 0; i < CODE_LEN; i++) begin
      mismatch[i] = (LEN_W'(i) < a_len_i) && (a_code_i[i] != b_code_i[i]);
    end
  end

  assign equal_o = (a_len_i == b_len_i) && (mismatch == '0);

endmodule

`default_nettype wire

// ===== src/keyed_access_controller.sv =====
// ----------------------------------------------------------------------------
// keyed_access_controller: command driven door access controller
// path: an accepted item is held in the input register, its result in the result register
// throughput: one item per cycle while out is not stalled, one pass of compare and update logic
//   between the input register and the result register
// backpressure: the result register holds while out is stalled, input
//   stage takes a new item as soon as its content moves on
// reset: asynchronous, active low; stored code ABCD, all drives off
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_access_controller #(
  parameter int unsigned CODE_LEN = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  kac_stream_if.sink         in_i,
  kac_stream_if.source       out_o
);

  localparam int unsigned LEN_W    = $clog2(CODE_LEN + 1);
  localparam int unsigned LETTER_W = kac_pkg::LETTER_W;
  localparam int unsigned HOLD_W   = kac_pkg::HOLD_W;
  localparam int unsigned HOUR_W   = kac_pkg::HOUR_W;
  localparam int unsigned MIN_W    = kac_pkg::MIN_W;
  // reset code is cut short when the code store is shorter than ABCD
  localparam int unsigned RST_LEN  = (CODE_LEN < kac_pkg::RESET_CODE_LEN) ?
                                     CODE_LEN : kac_pkg::RESET_CODE_LEN;

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic              in_valid_q;
  kac_pkg::kac_in_t  in_q;
  logic              out_valid_q;
  kac_pkg::kac_out_t out_q;
  logic              advance;     // result register may load
  logic              step_en;     // input item is processed this cycle
  logic              in_accept;

  assign advance   = !out_valid_q || out_o.ready;
  assign step_en   = advance && in_valid_q;
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  logic [LETTER_W-1:0] stored_q  [CODE_LEN];
  logic [LETTER_W-1:0] stored_d  [CODE_LEN];
  logic [LETTER_W-1:0] entered_q [CODE_LEN];
  logic [LETTER_W-1:0] entered_d [CODE_LEN];
  logic [LETTER_W-1:0] pending_q [CODE_LEN];
  logic [LETTER_W-1:0] pending_d [CODE_LEN];
  logic [LETTER_W-1:0] former_q  [CODE_LEN];
  logic [LETTER_W-1:0] former_d  [CODE_LEN];
  logic [LEN_W-1:0]    stored_len_q, stored_len_d;
  logic [LEN_W-1:0]    entered_len_q, entered_len_d;
  logic [LEN_W-1:0]    pending_len_q, pending_len_d;
  logic [LEN_W-1:0]    former_len_q, former_len_d;
  logic [7:0]          mode_q, mode_d;
  logic [HOLD_W-1:0]   hold_delay_q, hold_delay_d;
  logic                led_en_q, led_en_d;
  logic                sensor_en_q, sensor_en_d;
  logic [HOUR_W-1:0]   work_hours_q, work_hours_d;
  logic [HOUR_W-1:0]   hour_q, hour_d;
  logic [MIN_W-1:0]    minute_q, minute_d;
  logic                relay_q, relay_d;
  logic                green_q, green_d;
  logic                red_q, red_d;

  kac_pkg::kac_out_t   res_d;

  // --------------------------------------------------------------------------
  // code comparators: entry check and old code check
  // --------------------------------------------------------------------------
  logic entry_match;
  logic former_match;

  kac_code_eq #(
    .CODE_LEN (CODE_LEN)
  ) u_entry_eq (
    .a_code_i (stored_q),
    .a_len_i  (stored_len_q),
    .b_code_i (entered_q),
    .b_len_i  (entered_len_q),
    .equal_o  (entry_match)
  );

  kac_code_eq #(
    .CODE_LEN (CODE_LEN)
  ) u_former_eq (
    .a_code_i (former_q),
    .a_len_i  (former_len_q),
    .b_code_i (stored_q),
    .b_len_i  (stored_len_q),
    .equal_o  (former_match)
  );

  // --------------------------------------------------------------------------
  // one step of the controller
  // --------------------------------------------------------------------------
  logic [7:0] c;
  logic [7:0] up_off;    // offset from 'A'
  logic [7:0] lo_off;    // offset from 'a'
  logic       is_digit;
  logic       is_letter;
  logic       is_lower;
  logic       up_aj;
  logic       lo_aj;

  assign c         = in_q.rx_byte;
  assign up_off    = c - kac_pkg::CH_UP_A;
  assign lo_off    = c - kac_pkg::CH_LO_A;
  assign is_digit  = (c >= kac_pkg::CH_DIGIT_LO) && (c <= kac_pkg::CH_DIGIT_HI);
  assign is_letter = (c >= kac_pkg::CH_UP_A) && (c <= kac_pkg::CH_BAR);
  assign is_lower  = (c >= kac_pkg::CH_LO_A) && (c <= kac_pkg::CH_LO_Z);
  assign up_aj     = (c >= kac_pkg::CH_UP_A) && (c <= kac_pkg::CH_UP_J);
  assign lo_aj     = (c >= kac_pkg::CH_LO_A) && (c <= kac_pkg::CH_LO_J);

  always_comb begin
    stored_d      = stored_q;
    entered_d     = entered_q;
    pending_d     = pending_q;
    former_d      = former_q;
    stored_len_d  = stored_len_q;
    entered_len_d = entered_len_q;
    pending_len_d = pending_len_q;
    former_len_d  = former_len_q;
    mode_d        = mode_q;
    hold_delay_d  = hold_delay_q;
    led_en_d      = led_en_q;
    sensor_en_d   = sensor_en_q;
    work_hours_d  = work_hours_q;
    hour_d        = hour_q;
    minute_d      = minute_q;
    relay_d       = relay_q;
    green_d       = green_q;
    red_d         = red_q;
    res_d         = '0;

    if (in_q.operation == kac_pkg::OP_TICK) begin
      // minute tick, drive levels untouched
      if (minute_q < kac_pkg::MINUTE_WRAP) begin
        minute_d = minute_q + MIN_W'(1);
      end else begin
        minute_d = '0;
        hour_d   = (hour_q > kac_pkg::HOUR_LAST) ? '0 : hour_q + HOUR_W'(1);
      end
    end else begin
      if (in_q.has_byte) begin
        if (is_digit) begin
          mode_d = c;
          if (c == kac_pkg::CH_CHECK) begin
            // decision drives are cleared here, the closing sensor check sets them anew
            res_d.entry_decision = entry_match ? kac_pkg::DEC_GRANT : kac_pkg::DEC_DENY;
            res_d.hold_ms        = hold_delay_q;
            relay_d       = 1'b0;
            green_d       = 1'b0;
            red_d         = 1'b0;
            entered_d     = '{default: '0};
            former_d      = '{default: '0};
            entered_len_d = '0;
            former_len_d  = '0;
            mode_d        = kac_pkg::CH_IDLE;
          end else if (c == kac_pkg::CH_CHANGE) begin
            if ((pending_len_q != '0) && former_match) begin
              stored_d           = pending_q;
              stored_len_d       = pending_len_q;
              pending_d          = '{default: '0};
              pending_len_d      = '0;
              mode_d             = kac_pkg::CH_IDLE;
              res_d.green_blinks = kac_pkg::BLINK_SINGLE;
            end else begin
              res_d.red_blinks = kac_pkg::BLINK_SINGLE;
            end
            former_d     = '{default: '0};
            former_len_d = '0;
          end else begin
            entered_d     = '{default: '0};
            pending_d     = '{default: '0};
            entered_len_d = '0;
            pending_len_d = '0;
          end
        end else if (is_letter) begin
          unique case (mode_q)
            kac_pkg::CH_ENTER: begin
              // full codes ignore further letters: no slot matches the length
              if (up_aj) begin
                for (int i = 0; i < CODE_LEN; i++) begin
                  if (entered_len_q == LEN_W'(i)) entered_d[i] = c[LETTER_W-1:0];
                end
                if (entered_len_q < LEN_W'(CODE_LEN)) begin
                  entered_len_d = entered_len_q + LEN_W'(1);
                end
              end
              if (lo_aj) begin
                for (int i = 0; i < CODE_LEN; i++) begin
                  if (pending_len_q == LEN_W'(i)) pending_d[i] = c[LETTER_W-1:0];
                end
                if (pending_len_q < LEN_W'(CODE_LEN)) begin
                  pending_len_d = pending_len_q + LEN_W'(1);
                end
              end
            end
            kac_pkg::CH_ENABLES: begin
              if (is_lower) begin
                led_en_d = (c <= kac_pkg::CH_LO_M);
              end else begin
                sensor_en_d        = (c <= kac_pkg::CH_UP_M);
                res_d.green_blinks = kac_pkg::BLINK_SINGLE;
              end
            end
            kac_pkg::CH_HOURS: begin
              if (is_lower) begin
                if (c <= kac_pkg::CH_LO_X) work_hours_d = lo_off[HOUR_W-1:0];
              end else if (c <= kac_pkg::CH_UP_X) begin
                hour_d = up_off[HOUR_W-1:0];
              end
            end
            kac_pkg::CH_MINUTES: begin
              minute_d = up_off[MIN_W-1:0];
            end
            kac_pkg::CH_DELAY: begin
              if (is_lower) begin
                if (c <= kac_pkg::CH_LO_M) res_d.green_blinks = kac_pkg::BLINK_TEST;
                else                       res_d.red_blinks   = kac_pkg::BLINK_TEST;
              end else if ((c >= kac_pkg::CH_UP_D) && (c <= kac_pkg::CH_UP_K)) begin
                hold_delay_d = HOLD_W'(up_off[3:0]) * kac_pkg::HOLD_STEP;
              end
            end
            kac_pkg::CH_FORMER: begin
              if (up_aj) begin
                for (int i = 0; i < CODE_LEN; i++) begin
                  if (former_len_q == LEN_W'(i)) former_d[i] = c[LETTER_W-1:0];
                end
                if (former_len_q < LEN_W'(CODE_LEN)) begin
                  former_len_d = former_len_q + LEN_W'(1);
                end
              end
            end
            default: begin
              // letter outside any entry mode
              relay_d = 1'b0;
              green_d = 1'b0;
              red_d   = 1'b0;
            end
          endcase
        end
        // a requested blink clears its led here, before the closing sensor check
        if (res_d.green_blinks != kac_pkg::BLINK_NONE) green_d = 1'b0;
        if (res_d.red_blinks != kac_pkg::BLINK_NONE)   red_d   = 1'b0;
      end

      // sensor check closes every poll pass, with settings as just updated
      if (sensor_en_d && in_q.sensor_level) begin
        if (hour_d < work_hours_d) begin
          red_d   = 1'b0;
          relay_d = 1'b1;
          if (led_en_d) green_d = 1'b1;
        end else begin
          relay_d = 1'b0;
          green_d = 1'b0;
          red_d   = led_en_d;
        end
      end else begin
        relay_d = 1'b0;
        green_d = 1'b0;
        red_d   = 1'b0;
      end
    end

    res_d.relay_on = relay_d;
    res_d.green_on = green_d;
    res_d.red_on   = red_d;
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q  <= in_i.valid;
      if (advance)    out_valid_q <= in_valid_q;
    end
  end

  // payload stages carry no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) in_q  <= in_i.payload;
    if (step_en)   out_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        // letters are kept as their low nibble: A is 1, B is 2 and so on
        stored_q[i]  <= (i < RST_LEN) ? LETTER_W'(i + 1) : '0;
        entered_q[i] <= '0;
        pending_q[i] <= '0;
        former_q[i]  <= '0;
      end
      stored_len_q  <= LEN_W'(RST_LEN);
      entered_len_q <= '0;
      pending_len_q <= '0;
      former_len_q  <= '0;
      mode_q        <= '0;
      hold_delay_q  <= kac_pkg::HOLD_RST;
      led_en_q      <= 1'b1;
      sensor_en_q   <= 1'b1;
      work_hours_q  <= kac_pkg::WORK_HOURS_RST;
      hour_q        <= '0;
      minute_q      <= '0;
      relay_q       <= 1'b0;
      green_q       <= 1'b0;
      red_q         <= 1'b0;
    end else if (step_en) begin
      stored_q      <= stored_d;
      entered_q     <= entered_d;
      pending_q     <= pending_d;
      former_q      <= former_d;
      stored_len_q  <= stored_len_d;
      entered_len_q <= entered_len_d;
      pending_len_q <= pending_len_d;
      former_len_q  <= former_len_d;
      mode_q        <= mode_d;
      hold_delay_q  <= hold_delay_d;
      led_en_q      <= led_en_d;
      sensor_en_q   <= sensor_en_d;
      work_hours_q  <= work_hours_d;
      hour_q        <= hour_d;
      minute_q      <= minute_d;
      relay_q       <= relay_d;
      green_q       <= green_d;
      red_q         <= red_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/kac_checker.sv =====
// ----------------------------------------------------------------------------
// kac_checker: port level checks of the keyed access controller
// latency, drive level consistency, hold time with entry decision, result hold under backpressure
// ----------------------------------------------------------------------------
`default_nettype none

module kac_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire kac_pkg::kac_out_t out_data_i
);

  // a fresh result rises only after an item was accepted into the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without an item accepted two cycles earlier");

  // red never lit with the relay, green only with the relay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!(out_data_i.red_on && out_data_i.relay_on) &&
                     (!out_data_i.green_on || out_data_i.relay_on)))
    else $error("inconsistent drive levels");

  // a hold time comes exactly with an entry decision, and no blinks with it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (((out_data_i.entry_decision != kac_pkg::DEC_NONE) ==
                      (out_data_i.hold_ms != '0)) &&
                     ((out_data_i.entry_decision == kac_pkg::DEC_NONE) ||
                      ((out_data_i.green_blinks == kac_pkg::BLINK_NONE) &&
                       (out_data_i.red_blinks == kac_pkg::BLINK_NONE)))))
    else $error("hold time and entry decision disagree");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind keyed_access_controller kac_checker u_kac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);

`default_nettype wire
